FILE: design/wcni_pkg.sv
package wcni_pkg;

    localparam int QW            = 48;
    localparam int UW            = 47;
    localparam int GW            = 25;
    localparam int TAGW          = 8;
    localparam int IDXW          = 3;
    localparam int GAMMA_BITS    = 24;
    localparam int FRAC_BITS_DEF = 24;
    localparam int QUEUE_DEPTH   = 4;

    localparam logic OP_SNAPSHOT = 1'b0;
    localparam logic OP_CONTACT  = 1'b1;

    localparam logic [IDXW-1:0] REG_GAMMA_IN  = 3'd0;
    localparam logic [IDXW-1:0] REG_GAMMA_SEP = 3'd1;
    localparam logic [IDXW-1:0] REG_SOFTNESS  = 3'd2;
    localparam logic [IDXW-1:0] REG_NORMAL_DZ = 3'd3;
    localparam logic [IDXW-1:0] REG_IMPULSE_DZ = 3'd4;
    localparam logic [IDXW-1:0] REG_MAX_SEP   = 3'd5;
    localparam logic [IDXW-1:0] REG_SEP_ON    = 3'd6;

    localparam logic [GW-1:0] RST_GAMMA_IN   = 25'd14959300;
    localparam logic [GW-1:0] RST_GAMMA_SEP  = 25'd14959300;
    localparam logic [UW-1:0] RST_SOFTNESS   = 47'd13422;
    localparam logic [UW-1:0] RST_NORMAL_DZ  = 47'd16777;
    localparam logic [UW-1:0] RST_IMPULSE_DZ = 47'd8388608;
    localparam logic [UW-1:0] RST_MAX_SEP    = 47'd1677721600000;
    localparam logic          RST_SEP_ON     = 1'b0;

    localparam logic [GW-1:0] GAMMA_ONE = 25'd16777216;
    localparam logic signed [QW-1:0] QMAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [QW-1:0] QMIN = 48'sh8000_0000_0000;

    typedef struct packed {
        logic                   operation;
        logic signed [QW-1:0]   first_x;
        logic signed [QW-1:0]   first_y;
        logic signed [QW-1:0]   first_z;
        logic signed [QW-1:0]   second_x;
        logic signed [QW-1:0]   second_y;
        logic signed [QW-1:0]   second_z;
        logic [UW-1:0]          inv_mass_eff;
        logic                   new_contact;
        logic                   at_bump_stop;
        logic                   velocity_locked;
        logic [TAGW-1:0]        contact_tag;
    } t_item;

    typedef struct packed {
        logic [GW-1:0] gamma_inward;
        logic [GW-1:0] gamma_separating;
        logic [UW-1:0] softness;
        logic [UW-1:0] normal_deadzone;
        logic [UW-1:0] impulse_deadzone;
        logic [UW-1:0] max_separating_speed;
        logic          separating_damping_on;
    } t_cfg;

endpackage

FILE: design/wcni_front.sv
module wcni_front (
    input  logic           i_push,
    input  wcni_pkg::t_item i_item,
    input  logic           i_q_full,
    output logic           o_full,
    output logic           o_q_push
);
    import wcni_pkg::*;

    logic w_keep;

    // A contact with a zero normal or a zero inverse mass never yields an impulse.
    assign w_keep = (i_item.operation == OP_SNAPSHOT) ||
                    ((i_item.inv_mass_eff != '0) &&
                     ((i_item.first_x != '0) || (i_item.first_y != '0) ||
                      (i_item.first_z != '0)));

    assign o_full   = i_q_full;
    assign o_q_push = i_push && !i_q_full && w_keep;

endmodule

FILE: design/wcni_fifo.sv
module wcni_fifo #(
    parameter int DEPTH = wcni_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  wcni_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output wcni_pkg::t_item o_item,
    output logic            o_empty
);
    import wcni_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_item          r_mem [DEPTH];
    logic [AW-1:0]  r_wr;
    logic [AW-1:0]  r_rd;
    logic [CW-1:0]  r_cnt;
    logic           w_push;
    logic           w_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

FILE: design/wcni_mul.sv
module wcni_mul (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [47:0] i_a,
    input  logic [47:0] i_b,
    output logic        o_busy,
    output logic        o_done,
    output logic [95:0] o_prod
);
    logic [47:0] r_a;
    logic [47:0] r_b;
    logic [2:0]  r_cnt;
    logic        r_busy;
    logic        r_ppv;
    logic [1:0]  r_sel;
    logic [47:0] r_pp;
    logic [95:0] r_acc;
    logic        r_done;
    logic [23:0] w_ah;
    logic [23:0] w_bh;
    logic [95:0] w_sh;

    // Four 24x24 partial products, high or low half chosen by the count bits.
    assign w_ah = r_cnt[1] ? r_a[47:24] : r_a[23:0];
    assign w_bh = r_cnt[0] ? r_b[47:24] : r_b[23:0];

    always_comb begin
        case (r_sel)
            2'd0:    w_sh = 96'(r_pp);
            2'd1:    w_sh = 96'(r_pp) << 24;
            2'd2:    w_sh = 96'(r_pp) << 24;
            default: w_sh = 96'(r_pp) << 48;
        endcase
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_prod = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ppv  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a    <= i_a;
                r_b    <= i_b;
                r_cnt  <= '0;
                r_busy <= 1'b1;
                r_ppv  <= 1'b0;
                r_acc  <= '0;
            end else if (r_busy) begin
                if (r_cnt != 3'd4) begin
                    r_pp  <= w_ah * w_bh;
                    r_sel <= r_cnt[1:0];
                    r_ppv <= 1'b1;
                    r_cnt <= r_cnt + 1'b1;
                end else begin
                    r_ppv <= 1'b0;
                end
                if (r_ppv) begin
                    r_acc <= r_acc + w_sh;
                    if (r_sel == 2'd3) begin
                        r_done <= 1'b1;
                        r_busy <= 1'b0;
                    end
                end
            end
        end
    end

endmodule

FILE: design/wcni_div.sv
module wcni_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [79:0] i_dividend,
    input  logic [47:0] i_divisor,
    output logic        o_busy,
    output logic        o_done,
    output logic [79:0] o_quot
);
    logic [79:0] r_num;
    logic [47:0] r_rem;
    logic [79:0] r_quot;
    logic [47:0] r_d;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [48:0] w_trial;
    logic        w_ge;
    logic [48:0] w_diff;

    assign w_trial = {r_rem, r_num[79]};
    assign w_ge    = (w_trial >= {1'b0, r_d});
    assign w_diff  = w_trial - {1'b0, r_d};

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_num  <= i_dividend;
                r_d    <= i_divisor;
                r_rem  <= '0;
                r_quot <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem  <= w_ge ? w_diff[47:0] : w_trial[47:0];
                r_num  <= {r_num[78:0], 1'b0};
                r_quot <= {r_quot[78:0], w_ge};
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == 7'd79) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

FILE: design/wcni_back.sv
module wcni_back #(
    parameter int FRAC_BITS = wcni_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  wcni_pkg::t_cfg                  i_cfg,
    input  logic                            i_q_empty,
    input  wcni_pkg::t_item                 i_q_item,
    output logic                            o_q_pop,
    output logic                            o_empty,
    input  logic                            i_pop,
    output logic signed [wcni_pkg::QW-1:0]  o_impulse_x,
    output logic signed [wcni_pkg::QW-1:0]  o_impulse_y,
    output logic signed [wcni_pkg::QW-1:0]  o_impulse_z,
    output logic [wcni_pkg::TAGW-1:0]       o_result_tag,
    output logic                            o_separating_mode
);
    import wcni_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCALE = 4'd1;
    localparam logic [3:0] S_MUL   = 4'd2;
    localparam logic [3:0] S_MULW  = 4'd3;
    localparam logic [3:0] S_SQRT  = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_DIVW  = 4'd6;
    localparam logic [3:0] S_CLASS = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    localparam logic [4:0] MS_SQ_X   = 5'd0;
    localparam logic [4:0] MS_SQ_Y   = 5'd1;
    localparam logic [4:0] MS_SQ_Z   = 5'd2;
    localparam logic [4:0] MS_CX_A   = 5'd3;
    localparam logic [4:0] MS_CX_B   = 5'd4;
    localparam logic [4:0] MS_CY_A   = 5'd5;
    localparam logic [4:0] MS_CY_B   = 5'd6;
    localparam logic [4:0] MS_CZ_A   = 5'd7;
    localparam logic [4:0] MS_CZ_B   = 5'd8;
    localparam logic [4:0] MS_DOT_X  = 5'd9;
    localparam logic [4:0] MS_DOT_Y  = 5'd10;
    localparam logic [4:0] MS_DOT_Z  = 5'd11;
    localparam logic [4:0] MS_GAIN   = 5'd12;
    localparam logic [4:0] MS_IMP_X  = 5'd13;
    localparam logic [4:0] MS_IMP_Y  = 5'd14;
    localparam logic [4:0] MS_IMP_Z  = 5'd15;
    localparam logic [4:0] MS_ISQ_X  = 5'd16;
    localparam logic [4:0] MS_ISQ_Y  = 5'd17;
    localparam logic [4:0] MS_ISQ_Z  = 5'd18;
    localparam logic [4:0] MS_DZ_SQ  = 5'd19;

    localparam logic [1:0] DS_UX = 2'd0;
    localparam logic [1:0] DS_UY = 2'd1;
    localparam logic [1:0] DS_UZ = 2'd2;
    localparam logic [1:0] DS_JN = 2'd3;

    localparam logic signed [50:0] ACC_MAX = 51'sd140737488355327;
    localparam logic signed [50:0] ACC_MIN = -51'sd140737488355328;
    localparam logic [79:0] JN_MAX = 80'h7FFF_FFFF_FFFF;

    function automatic logic [QW-1:0] mag48(input logic signed [QW-1:0] x);
        logic [QW-1:0] neg;
        neg = ~x + 1'b1;
        return x[QW-1] ? neg : x;
    endfunction

    function automatic logic signed [50:0] sx51(input logic signed [QW-1:0] x);
        return $signed({{3{x[QW-1]}}, x});
    endfunction

    function automatic logic signed [QW-1:0] sat48(input logic signed [50:0] x);
        logic signed [QW-1:0] r;
        if (x > ACC_MAX) begin
            r = QMAX;
        end else if (x < ACC_MIN) begin
            r = QMIN;
        end else begin
            r = x[QW-1:0];
        end
        return r;
    endfunction

    logic [3:0]             r_state;
    logic [4:0]             r_step;
    logic [1:0]             r_dstep;
    logic signed [QW-1:0]   r_lv [3];
    logic signed [QW-1:0]   r_av [3];
    logic signed [QW-1:0]   r_s [3];
    logic [QW-1:0]          r_m [3];
    logic                   r_neg_n [3];
    logic [UW-1:0]          r_inv;
    logic                   r_push_in;
    logic                   r_locked;
    logic [TAGW-1:0]        r_tag;
    logic [63:0]            r_sum;
    logic [63:0]            r_sq_rem;
    logic [63:0]            r_sq_res;
    logic [63:0]            r_sq_bit;
    logic [32:0]            r_len;
    logic signed [QW-1:0]   r_n [3];
    logic signed [50:0]     r_acc;
    logic signed [QW-1:0]   r_vc [3];
    logic signed [QW-1:0]   r_vn;
    logic                   r_inward;
    logic [QW-1:0]          r_speed;
    logic [GW-1:0]          r_gam;
    logic [QW-1:0]          r_gv;
    logic [UW-1:0]          r_jn;
    logic signed [QW-1:0]   r_imp [3];
    logic [96:0]            r_isq;
    logic                   r_out_valid;

    logic [QW-1:0]          w_big;
    logic [47:0]            w_mul_a;
    logic [47:0]            w_mul_b;
    logic                   w_neg;
    logic                   w_mul_busy;
    logic                   w_mul_done;
    logic [95:0]            w_prod;
    logic [95:0]            w_shr;
    logic [QW-1:0]          w_mq_mag;
    logic signed [QW-1:0]   w_mq;
    logic signed [50:0]     w_mq51;
    logic [79:0]            w_div_n;
    logic [47:0]            w_div_d;
    logic                   w_div_busy;
    logic                   w_div_done;
    logic [79:0]            w_quot;
    logic signed [QW-1:0]   w_unit;
    logic [63:0]            w_sq_try;
    logic signed [48:0]     w_vn49;
    logic signed [48:0]     w_dz49;
    logic signed [48:0]     w_neg_vn;
    logic                   w_inward;
    logic                   w_sep;
    logic [QW-1:0]          w_sep_speed;
    logic [GW-1:0]          w_gam_raw;
    logic [47:0]            w_den;
    logic                   w_out_free;

    assign w_big = (r_m[0] >= r_m[1]) ? ((r_m[0] >= r_m[2]) ? r_m[0] : r_m[2])
                                      : ((r_m[1] >= r_m[2]) ? r_m[1] : r_m[2]);

    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        w_neg   = 1'b0;
        case (r_step)
            MS_SQ_X: begin w_mul_a = r_m[0]; w_mul_b = r_m[0]; end
            MS_SQ_Y: begin w_mul_a = r_m[1]; w_mul_b = r_m[1]; end
            MS_SQ_Z: begin w_mul_a = r_m[2]; w_mul_b = r_m[2]; end
            MS_CX_A: begin
                w_mul_a = mag48(r_av[1]); w_mul_b = mag48(r_s[2]);
                w_neg = r_av[1][QW-1] ^ r_s[2][QW-1];
            end
            MS_CX_B: begin
                w_mul_a = mag48(r_av[2]); w_mul_b = mag48(r_s[1]);
                w_neg = r_av[2][QW-1] ^ r_s[1][QW-1];
            end
            MS_CY_A: begin
                w_mul_a = mag48(r_av[2]); w_mul_b = mag48(r_s[0]);
                w_neg = r_av[2][QW-1] ^ r_s[0][QW-1];
            end
            MS_CY_B: begin
                w_mul_a = mag48(r_av[0]); w_mul_b = mag48(r_s[2]);
                w_neg = r_av[0][QW-1] ^ r_s[2][QW-1];
            end
            MS_CZ_A: begin
                w_mul_a = mag48(r_av[0]); w_mul_b = mag48(r_s[1]);
                w_neg = r_av[0][QW-1] ^ r_s[1][QW-1];
            end
            MS_CZ_B: begin
                w_mul_a = mag48(r_av[1]); w_mul_b = mag48(r_s[0]);
                w_neg = r_av[1][QW-1] ^ r_s[0][QW-1];
            end
            MS_DOT_X: begin
                w_mul_a = mag48(r_vc[0]); w_mul_b = mag48(r_n[0]);
                w_neg = r_vc[0][QW-1] ^ r_n[0][QW-1];
            end
            MS_DOT_Y: begin
                w_mul_a = mag48(r_vc[1]); w_mul_b = mag48(r_n[1]);
                w_neg = r_vc[1][QW-1] ^ r_n[1][QW-1];
            end
            MS_DOT_Z: begin
                w_mul_a = mag48(r_vc[2]); w_mul_b = mag48(r_n[2]);
                w_neg = r_vc[2][QW-1] ^ r_n[2][QW-1];
            end
            MS_GAIN: begin w_mul_a = 48'(r_gam); w_mul_b = r_speed; end
            MS_IMP_X: begin
                w_mul_a = 48'(r_jn); w_mul_b = mag48(r_n[0]);
                w_neg = !r_inward ^ r_n[0][QW-1];
            end
            MS_IMP_Y: begin
                w_mul_a = 48'(r_jn); w_mul_b = mag48(r_n[1]);
                w_neg = !r_inward ^ r_n[1][QW-1];
            end
            MS_IMP_Z: begin
                w_mul_a = 48'(r_jn); w_mul_b = mag48(r_n[2]);
                w_neg = !r_inward ^ r_n[2][QW-1];
            end
            MS_ISQ_X: begin w_mul_a = mag48(r_imp[0]); w_mul_b = mag48(r_imp[0]); end
            MS_ISQ_Y: begin w_mul_a = mag48(r_imp[1]); w_mul_b = mag48(r_imp[1]); end
            MS_ISQ_Z: begin w_mul_a = mag48(r_imp[2]); w_mul_b = mag48(r_imp[2]); end
            MS_DZ_SQ: begin
                w_mul_a = 48'(i_cfg.impulse_deadzone);
                w_mul_b = 48'(i_cfg.impulse_deadzone);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    wcni_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_MUL),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_busy  (w_mul_busy),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    // Fixed-point product: magnitude truncated, then saturated to the signed range.
    assign w_shr    = w_prod >> FRAC_BITS;
    assign w_mq_mag = {1'b0, w_shr[UW-1:0]};

    always_comb begin
        if (w_shr[95:UW] != '0) begin
            w_mq = w_neg ? QMIN : QMAX;
        end else begin
            w_mq = w_neg ? $signed(~w_mq_mag + 1'b1) : $signed(w_mq_mag);
        end
    end

    assign w_mq51 = sx51(w_mq);
    assign w_den  = {1'b0, r_inv} + {1'b0, i_cfg.softness};

    always_comb begin
        case (r_dstep)
            DS_UX:   w_div_n = 80'(r_m[0]) << FRAC_BITS;
            DS_UY:   w_div_n = 80'(r_m[1]) << FRAC_BITS;
            DS_UZ:   w_div_n = 80'(r_m[2]) << FRAC_BITS;
            default: w_div_n = 80'(r_gv) << FRAC_BITS;
        endcase
        w_div_d = (r_dstep == DS_JN) ? w_den : 48'(r_len);
    end

    wcni_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_DIV),
        .i_dividend (w_div_n),
        .i_divisor  (w_div_d),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    assign w_unit   = $signed({15'd0, w_quot[32:0]});
    assign w_sq_try = r_sq_res + r_sq_bit;

    assign w_vn49      = {r_vn[QW-1], r_vn};
    assign w_dz49      = $signed({2'b00, i_cfg.normal_deadzone});
    assign w_neg_vn    = -w_vn49;
    assign w_inward    = r_push_in && (w_vn49 < -w_dz49);
    assign w_sep       = i_cfg.separating_damping_on && r_locked && (w_vn49 > w_dz49);
    assign w_sep_speed = (r_vn[QW-1:0] > {1'b0, i_cfg.max_separating_speed})
                         ? {1'b0, i_cfg.max_separating_speed} : r_vn[QW-1:0];
    assign w_gam_raw   = w_inward ? i_cfg.gamma_inward : i_cfg.gamma_separating;

    assign w_out_free = !r_out_valid || i_pop;
    assign o_q_pop    = (r_state == S_IDLE) && !i_q_empty;
    assign o_empty    = !r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= MS_SQ_X;
            r_dstep     <= DS_UX;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_lv[i] <= '0;
                r_av[i] <= '0;
            end
        end else begin
            if (r_out_valid && i_pop) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        if (i_q_item.operation == OP_SNAPSHOT) begin
                            r_lv[0] <= i_q_item.first_x;
                            r_lv[1] <= i_q_item.first_y;
                            r_lv[2] <= i_q_item.first_z;
                            r_av[0] <= i_q_item.second_x;
                            r_av[1] <= i_q_item.second_y;
                            r_av[2] <= i_q_item.second_z;
                        end else begin
                            r_m[0]     <= mag48(i_q_item.first_x);
                            r_m[1]     <= mag48(i_q_item.first_y);
                            r_m[2]     <= mag48(i_q_item.first_z);
                            r_neg_n[0] <= i_q_item.first_x[QW-1];
                            r_neg_n[1] <= i_q_item.first_y[QW-1];
                            r_neg_n[2] <= i_q_item.first_z[QW-1];
                            r_s[0]     <= i_q_item.second_x;
                            r_s[1]     <= i_q_item.second_y;
                            r_s[2]     <= i_q_item.second_z;
                            r_inv      <= i_q_item.inv_mass_eff;
                            r_push_in  <= i_q_item.new_contact || i_q_item.at_bump_stop;
                            r_locked   <= i_q_item.velocity_locked;
                            r_tag      <= i_q_item.contact_tag;
                            r_state    <= S_SCALE;
                        end
                    end
                end
                S_SCALE: begin
                    // The largest magnitude is brought into [2^30, 2^31) one bit a cycle.
                    if (w_big >= 48'h8000_0000) begin
                        for (int i = 0; i < 3; i++) begin
                            r_m[i] <= r_m[i] >> 1;
                        end
                    end else if (w_big < 48'h4000_0000) begin
                        for (int i = 0; i < 3; i++) begin
                            r_m[i] <= r_m[i] << 1;
                        end
                    end else begin
                        r_step  <= MS_SQ_X;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_MULW;
                end
                S_MULW: begin
                    if (w_mul_done) begin
                        r_state <= S_MUL;
                        r_step  <= r_step + 1'b1;
                        case (r_step)
                            MS_SQ_X: r_sum <= w_prod[63:0];
                            MS_SQ_Y: r_sum <= r_sum + w_prod[63:0];
                            MS_SQ_Z: begin
                                r_sq_rem <= r_sum + w_prod[63:0];
                                r_sq_res <= '0;
                                r_sq_bit <= 64'h4000_0000_0000_0000;
                                r_state  <= S_SQRT;
                            end
                            MS_CX_A: r_acc <= sx51(r_lv[0]) + w_mq51;
                            MS_CX_B: r_vc[0] <= sat48(r_acc - w_mq51);
                            MS_CY_A: r_acc <= sx51(r_lv[1]) + w_mq51;
                            MS_CY_B: r_vc[1] <= sat48(r_acc - w_mq51);
                            MS_CZ_A: r_acc <= sx51(r_lv[2]) + w_mq51;
                            MS_CZ_B: r_vc[2] <= sat48(r_acc - w_mq51);
                            MS_DOT_X: r_acc <= w_mq51;
                            MS_DOT_Y: r_acc <= r_acc + w_mq51;
                            MS_DOT_Z: begin
                                r_vn    <= sat48(r_acc + w_mq51);
                                r_state <= S_CLASS;
                            end
                            MS_GAIN: begin
                                r_gv    <= w_prod[71:24];
                                r_dstep <= DS_JN;
                                r_state <= S_DIV;
                            end
                            MS_IMP_X: r_imp[0] <= w_mq;
                            MS_IMP_Y: r_imp[1] <= w_mq;
                            MS_IMP_Z: r_imp[2] <= w_mq;
                            MS_ISQ_X: r_isq <= 97'(w_prod);
                            MS_ISQ_Y: r_isq <= r_isq + 97'(w_prod);
                            MS_ISQ_Z: r_isq <= r_isq + 97'(w_prod);
                            MS_DZ_SQ: begin
                                r_state <= (r_isq < 97'(w_prod)) ? S_IDLE : S_OUT;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_SQRT: begin
                    if (r_sq_bit == '0) begin
                        r_len   <= r_sq_res[32:0];
                        r_dstep <= DS_UX;
                        r_state <= S_DIV;
                    end else begin
                        if (r_sq_rem >= w_sq_try) begin
                            r_sq_rem <= r_sq_rem - w_sq_try;
                            r_sq_res <= (r_sq_res >> 1) + r_sq_bit;
                        end else begin
                            r_sq_res <= r_sq_res >> 1;
                        end
                        r_sq_bit <= r_sq_bit >> 2;
                    end
                end
                S_DIV: begin
                    r_state <= S_DIVW;
                end
                S_DIVW: begin
                    if (w_div_done) begin
                        r_dstep <= r_dstep + 1'b1;
                        r_state <= S_DIV;
                        case (r_dstep)
                            DS_UX: r_n[0] <= r_neg_n[0] ? -w_unit : w_unit;
                            DS_UY: r_n[1] <= r_neg_n[1] ? -w_unit : w_unit;
                            DS_UZ: begin
                                r_n[2]  <= r_neg_n[2] ? -w_unit : w_unit;
                                r_step  <= MS_CX_A;
                                r_state <= S_MUL;
                            end
                            default: begin
                                r_jn   <= (w_quot > JN_MAX) ? JN_MAX[UW-1:0]
                                                            : w_quot[UW-1:0];
                                r_step <= MS_IMP_X;
                                r_state <= (w_quot == '0) ? S_IDLE : S_MUL;
                            end
                        endcase
                    end
                end
                S_CLASS: begin
                    if (!w_inward && !w_sep) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_inward <= w_inward;
                        r_speed  <= w_inward ? w_neg_vn[QW-1:0] : w_sep_speed;
                        r_gam    <= (w_gam_raw > GAMMA_ONE) ? GAMMA_ONE : w_gam_raw;
                        r_step   <= MS_GAIN;
                        r_state  <= S_MUL;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        o_impulse_x       <= r_imp[0];
                        o_impulse_y       <= r_imp[1];
                        o_impulse_z       <= r_imp[2];
                        o_result_tag      <= r_tag;
                        o_separating_mode <= !r_inward;
                        r_out_valid       <= 1'b1;
                        r_state           <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_mul_busy && w_div_busy))
        else $error("multiplier and divider busy together");

    a_mul_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_done |-> (r_state == S_MULW))
        else $error("product arrived outside its wait state");

    a_scale_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCALE) |-> ((r_m[0] | r_m[1] | r_m[2]) != '0))
        else $error("zero normal reached normalization");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) && r_out_valid && !i_pop |=> (r_state == S_OUT))
        else $error("result left while output register was occupied");

endmodule

FILE: design/wheel_contact_normal_impulse_unit.sv
// Channel   Direction  Handshake                 Payload
// input     in         push / full               operation, first_*, second_*, inv_mass_eff,
//                                                new_contact, at_bump_stop, velocity_locked,
//                                                contact_tag
// result    out        empty / pop               impulse_*, result_tag, separating_mode
// config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// A snapshot is stored by the back end from its idle state; a contact with a zero
// normal or zero inverse mass is dropped at the front and never reaches it.
// A solved contact is paced mostly by the shared divider, which retires one quotient
// bit a cycle for the three unit components and the impulse, and by the shared
// multiplier, which forms each 48x48 product from 24x24 partial products.
// The front keeps accepting into a four-entry queue while the back end works. A result
// waits in the output register; the next item is solved but held until that is popped.
// Reset is synchronous and active low; it restores register defaults and clears the
// velocity snapshot.
module wheel_contact_normal_impulse_unit #(
    parameter int FRAC_BITS   = wcni_pkg::FRAC_BITS_DEF,
    parameter int QUEUE_DEPTH = wcni_pkg::QUEUE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic                            i_operation,
    input  logic signed [wcni_pkg::QW-1:0]  i_first_x,
    input  logic signed [wcni_pkg::QW-1:0]  i_first_y,
    input  logic signed [wcni_pkg::QW-1:0]  i_first_z,
    input  logic signed [wcni_pkg::QW-1:0]  i_second_x,
    input  logic signed [wcni_pkg::QW-1:0]  i_second_y,
    input  logic signed [wcni_pkg::QW-1:0]  i_second_z,
    input  logic [wcni_pkg::UW-1:0]         i_inv_mass_eff,
    input  logic                            i_new_contact,
    input  logic                            i_at_bump_stop,
    input  logic                            i_velocity_locked,
    input  logic [wcni_pkg::TAGW-1:0]       i_contact_tag,
    output logic                            empty,
    input  logic                            pop,
    output logic signed [wcni_pkg::QW-1:0]  o_impulse_x,
    output logic signed [wcni_pkg::QW-1:0]  o_impulse_y,
    output logic signed [wcni_pkg::QW-1:0]  o_impulse_z,
    output logic [wcni_pkg::TAGW-1:0]       o_result_tag,
    output logic                            o_separating_mode,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [wcni_pkg::IDXW-1:0]       i_cfg_index,
    input  logic [wcni_pkg::UW-1:0]         i_cfg_data
);
    import wcni_pkg::*;

    t_cfg  r_cfg;
    t_item w_item;
    t_item w_q_item;
    logic  w_q_full;
    logic  w_q_push;
    logic  w_q_pop;
    logic  w_q_empty;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gamma_inward          <= RST_GAMMA_IN;
            r_cfg.gamma_separating      <= RST_GAMMA_SEP;
            r_cfg.softness              <= RST_SOFTNESS;
            r_cfg.normal_deadzone       <= RST_NORMAL_DZ;
            r_cfg.impulse_deadzone      <= RST_IMPULSE_DZ;
            r_cfg.max_separating_speed  <= RST_MAX_SEP;
            r_cfg.separating_damping_on <= RST_SEP_ON;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_GAMMA_IN:   r_cfg.gamma_inward          <= i_cfg_data[GW-1:0];
                REG_GAMMA_SEP:  r_cfg.gamma_separating      <= i_cfg_data[GW-1:0];
                REG_SOFTNESS:   r_cfg.softness              <= i_cfg_data;
                REG_NORMAL_DZ:  r_cfg.normal_deadzone       <= i_cfg_data;
                REG_IMPULSE_DZ: r_cfg.impulse_deadzone      <= i_cfg_data;
                REG_MAX_SEP:    r_cfg.max_separating_speed  <= i_cfg_data;
                REG_SEP_ON:     r_cfg.separating_damping_on <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_item.operation       = i_operation;
        w_item.first_x         = i_first_x;
        w_item.first_y         = i_first_y;
        w_item.first_z         = i_first_z;
        w_item.second_x        = i_second_x;
        w_item.second_y        = i_second_y;
        w_item.second_z        = i_second_z;
        w_item.inv_mass_eff    = i_inv_mass_eff;
        w_item.new_contact     = i_new_contact;
        w_item.at_bump_stop    = i_at_bump_stop;
        w_item.velocity_locked = i_velocity_locked;
        w_item.contact_tag     = i_contact_tag;
    end

    wcni_front u_front (
        .i_push   (push),
        .i_item   (w_item),
        .i_q_full (w_q_full),
        .o_full   (full),
        .o_q_push (w_q_push)
    );

    wcni_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_item  (w_item),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_item  (w_q_item),
        .o_empty (w_q_empty)
    );

    wcni_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_q_empty         (w_q_empty),
        .i_q_item          (w_q_item),
        .o_q_pop           (w_q_pop),
        .o_empty           (empty),
        .i_pop             (pop),
        .o_impulse_x       (o_impulse_x),
        .o_impulse_y       (o_impulse_y),
        .o_impulse_z       (o_impulse_z),
        .o_result_tag      (o_result_tag),
        .o_separating_mode (o_separating_mode)
    );

endmodule
